// File: rtl/tcw_pkg.sv
// shared types, codes and palette tables of the text console writer
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam logic [7:0]  GLYPH_NEWLINE = 8'd10;
  localparam logic [7:0]  GLYPH_SPACE   = 8'h20;
  localparam logic [15:0] SPACE_CELL    = 16'h0020;

  localparam int PAL_SIZE = 16;
  localparam int PAL_W    = 4;
  localparam int DIST_W   = 18;

  localparam logic [7:0] PAL_RED [PAL_SIZE] = '{
    8'd0, 8'd0, 8'd0, 8'd0, 8'd170, 8'd170, 8'd170, 8'd170,
    8'd85, 8'd85, 8'd85, 8'd85, 8'd255, 8'd255, 8'd255, 8'd255};
  localparam logic [7:0] PAL_GREEN [PAL_SIZE] = '{
    8'd0, 8'd0, 8'd170, 8'd170, 8'd0, 8'd0, 8'd85, 8'd170,
    8'd85, 8'd85, 8'd255, 8'd255, 8'd85, 8'd85, 8'd255, 8'd255};
  localparam logic [7:0] PAL_BLUE [PAL_SIZE] = '{
    8'd0, 8'd170, 8'd0, 8'd170, 8'd0, 8'd170, 8'd0, 8'd170,
    8'd85, 8'd255, 8'd85, 8'd255, 8'd85, 8'd255, 8'd85, 8'd255};

  typedef enum logic [2:0] {
    ACT_PUT        = 3'd0,
    ACT_PUT_AT     = 3'd1,
    ACT_BACKSPACE  = 3'd2,
    ACT_CLEAR      = 3'd3,
    ACT_FILL       = 3'd4,
    ACT_SCROLL     = 3'd5,
    ACT_SET_CURSOR = 3'd6,
    ACT_READ       = 3'd7
  } tcw_action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_COLOR,
    ST_WRITE,
    ST_READ,
    ST_SCROLL_RD,
    ST_SCROLL_WR,
    ST_FILL,
    ST_RESP
  } tcw_state_t;

  typedef struct packed {
    tcw_action_t action;
    logic [7:0]  glyph;
    logic [23:0] rgb_color;
    logic [7:0]  column;
    logic [7:0]  line;
  } tcw_cmd_t;

  typedef struct packed {
    logic [6:0]  write_column;
    logic [4:0]  write_line;
    logic [10:0] cursor_index;
    logic [7:0]  cell_glyph;
    logic [7:0]  cell_attr;
    logic        ignored;
  } tcw_rsp_t;

endpackage

// File: rtl/tcw_palette.sv
// iterative nearest palette color search, one palette entry per cycle
module tcw_palette (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [23:0] rgb_color,
  output logic        done,
  output logic [3:0]  index
);
  import tcw_pkg::*;

  logic              busy;
  logic [PAL_W-1:0]  cnt;
  logic [DIST_W-1:0] min_dist;
  logic [PAL_W-1:0]  best_idx;
  logic [7:0]        red, green, blue;
  logic [7:0]        dr, dg, db;
  logic [DIST_W-1:0] cand_dist;
  logic              closer;

  assign red   = rgb_color[23:16];
  assign green = rgb_color[15:8];
  assign blue  = rgb_color[7:0];

  always_comb begin
    dr = (red > PAL_RED[cnt]) ? red - PAL_RED[cnt] : PAL_RED[cnt] - red;
    dg = (green > PAL_GREEN[cnt]) ? green - PAL_GREEN[cnt] : PAL_GREEN[cnt] - green;
    db = (blue > PAL_BLUE[cnt]) ? blue - PAL_BLUE[cnt] : PAL_BLUE[cnt] - blue;
    cand_dist = DIST_W'(16'(dr) * 16'(dr)) + DIST_W'(16'(dg) * 16'(dg))
              + DIST_W'(16'(db) * 16'(db));
    closer = cand_dist < min_dist;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        min_dist <= '1;
        best_idx <= '0;
      end else if (busy) begin
        if (closer) begin
          min_dist <= cand_dist;
          best_idx <= cnt;
        end
        cnt <= cnt + 1'b1;
        if (cnt == PAL_W'(PAL_SIZE - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign index = best_idx;

endmodule

// File: rtl/tcw_screen_ram.sv
// screen cell memory, one write port and one registered read port
module tcw_screen_ram #(
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = 11
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [15:0]       wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [15:0]       rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/text_console_writer_core.sv
// text console writer top level: command sequencer, position and cursor registers
//
// Commands arrive on the cmd channel (valid/ready), one beat per command, and
// each command yields exactly one beat on the rsp channel with the write
// position, the hardware cursor and, for a read, the cell contents.
// The block works on one command at a time; cmd_ready is high only while the
// sequencer is idle, and a new command is taken while the previous response
// still waits in the rsp register.
// Steps from accept to response:
//   set cursor, newline without scroll, off-screen target: decode, then respond
//   backspace: decode, write the blank cell; read: decode, read the cell
//   put, put at: wait for the 16-entry palette search that
//     evaluates one palette entry per cycle, then write the cell
//   clear: write spaces to every cell, one cell written per cycle
//   fill: palette search, then write every cell with that colour
//   scroll: one memory port pair moves each cell up a row, read then write,
//     then blanks the bottom row (a put at the bottom right also scrolls)
// After reset the screen memory is cleared to zero, all COLUMNS*ROWS cells
// (2000 at 80x25), with cmd_ready low. A stalled rsp_ready holds the response
// and the sequencer in its final state until the beat is taken.
module text_console_writer_core #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  tcw_pkg::tcw_cmd_t cmd,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output tcw_pkg::tcw_rsp_t rsp
);
  import tcw_pkg::*;

  localparam int CELLS       = COLUMNS * ROWS;
  localparam int ADDR_W      = $clog2(CELLS);
  localparam int COL_W       = $clog2(COLUMNS);
  localparam int ROW_W       = $clog2(ROWS);
  localparam int BOTTOM_BASE = (ROWS - 1) * COLUMNS;
  localparam int LAST_MOVE   = BOTTOM_BASE - 1;

  tcw_state_t        state, state_next;
  tcw_cmd_t          cur;
  logic [COL_W-1:0]  pos_col;
  logic [ROW_W-1:0]  pos_line;
  logic [ADDR_W-1:0] cursor;
  logic [ADDR_W-1:0] idx;
  logic [15:0]       fill_cell;
  logic              boot;
  logic [7:0]        rd_glyph, rd_attr;
  logic              ign;

  logic              pal_start, pal_done;
  logic [3:0]        pal_idx;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [15:0]       ram_wdata, ram_rdata;

  logic              tgt_on, need_colour, last_col, last_row, rsp_free;
  logic [ADDR_W-1:0] tgt_addr, pos_addr;
  logic [ROW_W-1:0]  nl_line, adv_line;
  logic [COL_W-1:0]  adv_col, clamp_col;
  logic [ROW_W-1:0]  clamp_line;
  logic [7:0]        col_cl, line_cl;

  function automatic logic [ADDR_W-1:0] cell_index(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    return ADDR_W'(ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c));
  endfunction

  tcw_palette u_palette (
    .clk       (clk),
    .rst       (rst),
    .start     (pal_start),
    .rgb_color (cur.rgb_color),
    .done      (pal_done),
    .index     (pal_idx)
  );

  tcw_screen_ram #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_screen_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    tgt_on      = (cur.column < 8'(COLUMNS)) && (cur.line < 8'(ROWS));
    tgt_addr    = cell_index(cur.line[ROW_W-1:0], cur.column[COL_W-1:0]);
    pos_addr    = cell_index(pos_line, pos_col);
    last_col    = pos_col == COL_W'(COLUMNS - 1);
    last_row    = pos_line == ROW_W'(ROWS - 1);
    nl_line     = last_row ? pos_line : pos_line + 1'b1;
    adv_col     = last_col ? '0 : pos_col + 1'b1;
    adv_line    = last_col ? nl_line : pos_line;
    col_cl      = (cur.column >= 8'(COLUMNS)) ? 8'(COLUMNS - 1) : cur.column;
    line_cl     = (cur.line >= 8'(ROWS)) ? 8'(ROWS - 1) : cur.line;
    clamp_col   = col_cl[COL_W-1:0];
    clamp_line  = line_cl[ROW_W-1:0];
    need_colour = ((cur.action == ACT_PUT) && (cur.glyph != GLYPH_NEWLINE))
               || ((cur.action == ACT_PUT_AT) && tgt_on)
               || (cur.action == ACT_FILL);
    rsp_free    = !rsp_valid || rsp_ready;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (cur.action)
          ACT_PUT: begin
            if (cur.glyph != GLYPH_NEWLINE) state_next = ST_COLOR;
            else if (last_row) state_next = ST_SCROLL_RD;
            else state_next = ST_RESP;
          end
          ACT_PUT_AT:     state_next = tgt_on ? ST_COLOR : ST_RESP;
          ACT_BACKSPACE:  state_next = ST_WRITE;
          ACT_CLEAR:      state_next = ST_FILL;
          ACT_FILL:       state_next = ST_COLOR;
          ACT_SCROLL:     state_next = ST_SCROLL_RD;
          ACT_SET_CURSOR: state_next = ST_RESP;
          ACT_READ:       state_next = tgt_on ? ST_READ : ST_RESP;
        endcase
      end
      ST_COLOR: begin
        if (pal_done) begin
          if (cur.action == ACT_FILL) state_next = ST_FILL;
          else if (cur.action == ACT_PUT && last_col && last_row) state_next = ST_SCROLL_RD;
          else state_next = ST_RESP;
        end
      end
      ST_WRITE:     state_next = ST_RESP;
      ST_READ:      state_next = ST_RESP;
      ST_SCROLL_RD: state_next = ST_SCROLL_WR;
      ST_SCROLL_WR: begin
        state_next = (idx == ADDR_W'(LAST_MOVE)) ? ST_FILL : ST_SCROLL_RD;
      end
      ST_FILL: begin
        if (idx == ADDR_W'(CELLS - 1)) state_next = boot ? ST_IDLE : ST_RESP;
      end
      ST_RESP: begin
        if (rsp_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    cmd_ready = 1'b0;
    pal_start = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = pos_addr;
    ram_wdata = SPACE_CELL;
    ram_raddr = tgt_addr;
    unique case (state)
      ST_IDLE:   cmd_ready = 1'b1;
      ST_DECODE: pal_start = need_colour;
      ST_COLOR: begin
        ram_wdata = {4'h0, pal_idx, cur.glyph};
        if (pal_done && cur.action == ACT_PUT) begin
          ram_we = 1'b1;
        end else if (pal_done && cur.action == ACT_PUT_AT) begin
          ram_we    = 1'b1;
          ram_waddr = tgt_addr;
        end
      end
      ST_WRITE: ram_we = 1'b1;
      ST_READ: ;
      ST_SCROLL_RD: ram_raddr = ADDR_W'(idx + ADDR_W'(COLUMNS));
      ST_SCROLL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = ram_rdata;
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = fill_cell;
      end
      ST_RESP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == ST_RESP && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_col   <= '0;
      pos_line  <= '0;
      cursor    <= '0;
      idx       <= '0;
      fill_cell <= '0;
      boot      <= 1'b1;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            cur      <= cmd;
            rd_glyph <= '0;
            rd_attr  <= '0;
            ign      <= 1'b0;
          end
        end
        ST_DECODE: begin
          unique case (cur.action)
            ACT_PUT: begin
              if (cur.glyph == GLYPH_NEWLINE) begin
                pos_col  <= '0;
                pos_line <= nl_line;
                cursor   <= cell_index(nl_line, '0);
                idx      <= '0;
              end
            end
            ACT_PUT_AT: ign <= !tgt_on;
            ACT_BACKSPACE: begin
              if (pos_col == '0) begin
                if (pos_line != '0) begin
                  pos_line <= pos_line - 1'b1;
                  pos_col  <= COL_W'(COLUMNS - 1);
                end
              end else begin
                pos_col <= pos_col - 1'b1;
              end
            end
            ACT_CLEAR: begin
              pos_col   <= '0;
              pos_line  <= '0;
              cursor    <= '0;
              idx       <= '0;
              fill_cell <= SPACE_CELL;
            end
            ACT_FILL: ;
            ACT_SCROLL: begin
              if (pos_line != '0) pos_line <= pos_line - 1'b1;
              idx <= '0;
            end
            ACT_SET_CURSOR: cursor <= cell_index(clamp_line, clamp_col);
            ACT_READ:       ign <= !tgt_on;
          endcase
        end
        ST_COLOR: begin
          if (pal_done) begin
            if (cur.action == ACT_PUT) begin
              pos_col  <= adv_col;
              pos_line <= adv_line;
              cursor   <= cell_index(adv_line, adv_col);
              idx      <= '0;
            end else if (cur.action == ACT_FILL) begin
              fill_cell <= {pal_idx, pal_idx, GLYPH_SPACE};
              idx       <= '0;
            end
          end
        end
        ST_WRITE: cursor <= pos_addr;
        ST_READ: begin
          rd_glyph <= ram_rdata[7:0];
          rd_attr  <= ram_rdata[15:8];
        end
        ST_SCROLL_RD: ;
        ST_SCROLL_WR: begin
          if (idx == ADDR_W'(LAST_MOVE)) begin
            idx       <= ADDR_W'(BOTTOM_BASE);
            fill_cell <= SPACE_CELL;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_FILL: begin
          idx <= idx + 1'b1;
          if (idx == ADDR_W'(CELLS - 1)) boot <= 1'b0;
        end
        ST_RESP: begin
          if (rsp_free) begin
            rsp.write_column <= 7'(pos_col);
            rsp.write_line   <= 5'(pos_line);
            rsp.cursor_index <= 11'(cursor);
            rsp.cell_glyph   <= rd_glyph;
            rsp.cell_attr    <= rd_attr;
            rsp.ignored      <= ign;
          end
        end
        default: ;
      endcase
    end
  end

  a_pos_col_range: assert property (@(posedge clk) disable iff (rst)
    32'(pos_col) < COLUMNS)
    else $error("write column beyond last column");

  a_pos_line_range: assert property (@(posedge clk) disable iff (rst)
    32'(pos_line) < ROWS)
    else $error("write row beyond last row");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    32'(cursor) < CELLS)
    else $error("cursor beyond screen");

  a_one_cmd_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken while another is in flight");

  a_rsp_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    state == ST_RESP && rsp_valid && !rsp_ready |=> state == ST_RESP)
    else $error("response overwritten while stalled");

endmodule

// File: test/text_console_writer_checker.sv
// text console writer checker: mirrors the screen, predicts each response beat and compares it
`timescale 1ns / 100ps
module text_console_writer_checker #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  logic              cmd_ready,
  input  tcw_pkg::tcw_cmd_t cmd,
  input  logic              rsp_valid,
  input  logic              rsp_ready,
  input  tcw_pkg::tcw_rsp_t rsp,
  output int                errors,
  output int                pending,
  output int                checked
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;

  logic [15:0] screen [CELLS];
  int          wr_col;
  int          wr_row;
  int          cursor_pos;
  tcw_rsp_t    pending_status [$];

  // chan 0 blue, 1 green, 2 red; index 6 is brown, its green drops to the dim level
  function automatic int palette_level(int idx, int chan);
    int lvl;
    lvl = idx[chan] ? 170 : 0;
    if (idx[3]) lvl += 85;
    if (idx == 6 && chan == 1) lvl = 85;
    return lvl;
  endfunction

  function automatic logic [3:0] nearest_palette(logic [23:0] rgb);
    int best;
    int min_dist;
    int sum_sq;
    int diff;
    best = 0;
    min_dist = 32'h7fff_ffff;
    for (int i = 0; i < 16; i++) begin
      sum_sq = 0;
      for (int ch = 0; ch < 3; ch++) begin
        diff = int'(rgb[ch*8 +: 8]) - palette_level(i, ch);
        sum_sq += diff * diff;
      end
      // strict compare keeps the lowest index on a tie
      if (sum_sq < min_dist) begin
        min_dist = sum_sq;
        best = i;
      end
    end
    return best[3:0];
  endfunction

  function automatic void scroll_screen();
    for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
      screen[i] = screen[i + COLUMNS];
    for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++)
      screen[i] = SPACE_CELL;
    if (wr_row > 0) wr_row--;
  endfunction

  function automatic void advance_row();
    wr_col = 0;
    wr_row++;
    if (wr_row >= ROWS) begin
      scroll_screen();
      wr_row = ROWS - 1;
    end
  endfunction

  function automatic void cursor_at(int col, int row);
    if (col >= COLUMNS) col = COLUMNS - 1;
    if (row >= ROWS) row = ROWS - 1;
    cursor_pos = row * COLUMNS + col;
  endfunction

  function automatic tcw_rsp_t apply_console_command(tcw_cmd_t c);
    tcw_rsp_t   r;
    int         col;
    int         row;
    logic       on_screen;
    logic [3:0] shade;
    r = '0;
    col = int'(c.column);
    row = int'(c.line);
    on_screen = (col < COLUMNS) && (row < ROWS);
    case (c.action)
      ACT_PUT: begin
        if (c.glyph == GLYPH_NEWLINE) begin
          advance_row();
        end else begin
          screen[wr_row * COLUMNS + wr_col] = {4'h0, nearest_palette(c.rgb_color), c.glyph};
          wr_col++;
          if (wr_col >= COLUMNS) advance_row();
        end
        cursor_at(wr_col, wr_row);
      end
      ACT_PUT_AT: begin
        if (on_screen)
          screen[row * COLUMNS + col] = {4'h0, nearest_palette(c.rgb_color), c.glyph};
        else
          r.ignored = 1'b1;
      end
      ACT_BACKSPACE: begin
        if (wr_col == 0) begin
          if (wr_row > 0) begin
            wr_row--;
            wr_col = COLUMNS - 1;
          end
        end else begin
          wr_col--;
        end
        screen[wr_row * COLUMNS + wr_col] = SPACE_CELL;
        cursor_at(wr_col, wr_row);
      end
      ACT_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen[i] = SPACE_CELL;
        wr_col = 0;
        wr_row = 0;
        cursor_pos = 0;
      end
      ACT_FILL: begin
        shade = nearest_palette(c.rgb_color);
        for (int i = 0; i < CELLS; i++) screen[i] = {shade, shade, GLYPH_SPACE};
      end
      ACT_SCROLL: begin
        scroll_screen();
      end
      ACT_SET_CURSOR: begin
        cursor_at(col, row);
      end
      ACT_READ: begin
        if (on_screen)
          {r.cell_attr, r.cell_glyph} = screen[row * COLUMNS + col];
        else
          r.ignored = 1'b1;
      end
    endcase
    r.write_column = wr_col[6:0];
    r.write_line   = wr_row[4:0];
    r.cursor_index = cursor_pos[10:0];
    return r;
  endfunction

  task automatic compare_field(string field, int want, int got);
    if (want != got) begin
      errors++;
      if (errors <= 10)
        $display("%t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    tcw_rsp_t want;
    if (rst) begin
      for (int i = 0; i < CELLS; i++) screen[i] = '0;
      wr_col = 0;
      wr_row = 0;
      cursor_pos = 0;
      pending_status.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (pending_status.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%t: response beat with nothing outstanding", $time);
        end else begin
          want = pending_status.pop_front();
          checked++;
          compare_field("write_column", int'(want.write_column), int'(rsp.write_column));
          compare_field("write_line", int'(want.write_line), int'(rsp.write_line));
          compare_field("cursor_index", int'(want.cursor_index), int'(rsp.cursor_index));
          compare_field("cell_glyph", int'(want.cell_glyph), int'(rsp.cell_glyph));
          compare_field("cell_attr", int'(want.cell_attr), int'(rsp.cell_attr));
          compare_field("ignored", int'(want.ignored), int'(rsp.ignored));
        end
      end
      if (cmd_valid && cmd_ready) pending_status.push_back(apply_console_command(cmd));
    end
    pending = pending_status.size();
  end

endmodule

// File: test/text_console_writer_core_tb.sv
// text console writer testbench top: clock, reset, command stimulus, pacing phases and verdict
`timescale 1ns / 100ps
module text_console_writer_core_tb;
  import tcw_pkg::*;

  localparam int COLUMNS          = COLUMNS_DEF;
  localparam int ROWS             = ROWS_DEF;
  localparam int CELLS            = COLUMNS * ROWS;
  localparam int SCROLL_CYCLES    = 2 * (ROWS - 1) * COLUMNS + COLUMNS;
  localparam int RANDOM_PER_PHASE = 356;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     cmd_valid = 1'b0;
  logic     rsp_ready = 1'b0;
  tcw_cmd_t cmd       = '0;
  logic     cmd_ready;
  logic     rsp_valid;
  tcw_rsp_t rsp;

  int         errors;
  int         pending;
  int         checked;
  int         idle_pct     = 0;
  int         stall_pct    = 0;
  int         sent         = 0;
  int         offscreen    = 0;
  int         reads        = 0;
  int         wide_ops     = 0;
  int         cycles       = 0;
  int         cycle_budget = 0;
  logic [4:0] last_row     = '0;

  int idle_mode  [4] = '{0, 79, 0, 25};
  int stall_mode [4] = '{0, 0, 79, 25};

  text_console_writer_core #(.COLUMNS(COLUMNS), .ROWS(ROWS)) dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  text_console_writer_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) screen_check (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .errors(errors),
    .pending(pending),
    .checked(checked)
  );

  always #4 clk = ~clk;

  always @(negedge clk) rsp_ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if (rsp_valid && rsp_ready) last_row <= rsp.write_line;
  end

  // limit grows with every command by a budget for its command kind, reset clearing pass included
  always @(posedge clk) begin
    cycles++;
    if (cycles > 4 * cycle_budget + 4 * CELLS + 20000) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycles, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic tcw_cmd_t make_cmd(tcw_action_t act, logic [7:0] glyph,
                                        logic [23:0] rgb, logic [7:0] col, logic [7:0] row);
    tcw_cmd_t c;
    c.action    = act;
    c.glyph     = glyph;
    c.rgb_color = rgb;
    c.column    = col;
    c.line      = row;
    return c;
  endfunction

  task automatic send_cmd(tcw_cmd_t c);
    logic off;
    off = (c.action == ACT_PUT_AT || c.action == ACT_READ) &&
          (c.column >= COLUMNS || c.line >= ROWS);
    while ($urandom_range(99) < idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd       <= c;
    cmd_valid <= 1'b1;
    case (c.action)
      ACT_PUT:               cycle_budget += (c.glyph == GLYPH_NEWLINE) ?
                                             SCROLL_CYCLES + 100 : 200;
      ACT_SCROLL:            cycle_budget += SCROLL_CYCLES + 100;
      ACT_CLEAR, ACT_FILL:   cycle_budget += CELLS + 100;
      default:               cycle_budget += 100;
    endcase
    if (c.action == ACT_READ) reads++;
    if (c.action == ACT_CLEAR || c.action == ACT_FILL || c.action == ACT_SCROLL) wide_ops++;
    if (off) offscreen++;
    else sent++;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pick_target(output logic [7:0] col, output logic [7:0] row);
    int sel;
    sel = $urandom_range(9);
    if (sel < 2) begin
      col = 8'($urandom);
      row = 8'($urandom);
    end else begin
      col = 8'($urandom_range(COLUMNS - 1));
      if (sel < 6)
        row = (last_row > 0 && $urandom_range(1) == 1) ? 8'(last_row - 1'b1) : 8'(last_row);
      else
        row = 8'($urandom_range(ROWS - 1));
    end
  endtask

  task automatic random_burst();
    int         pick;
    int         len;
    logic [7:0] g;
    logic [7:0] col;
    logic [7:0] row;
    pick = $urandom_range(199);
    if (pick < 50) begin
      // a line of text, now and then long enough to wrap
      len = ($urandom_range(4) == 0) ? $urandom_range(60, 90) : $urandom_range(1, 12);
      for (int k = 0; k < len; k++) begin
        g = 8'($urandom);
        if (g == GLYPH_NEWLINE) g = GLYPH_SPACE;
        send_cmd(make_cmd(ACT_PUT, g, 24'($urandom), 8'($urandom), 8'($urandom)));
      end
      if ($urandom_range(9) < 6)
        send_cmd(make_cmd(ACT_PUT, GLYPH_NEWLINE, 24'($urandom), 8'($urandom), 8'($urandom)));
    end else if (pick < 52) begin
      // run the write row down to the bottom
      for (int k = 0; k < ROWS - 1; k++)
        send_cmd(make_cmd(ACT_PUT, GLYPH_NEWLINE, 24'($urandom), 8'($urandom), 8'($urandom)));
    end else if (pick < 55) begin
      send_cmd(make_cmd(ACT_CLEAR, 8'($urandom), 24'($urandom), 8'($urandom), 8'($urandom)));
    end else if (pick < 57) begin
      send_cmd(make_cmd(ACT_FILL, 8'($urandom), 24'($urandom), 8'($urandom), 8'($urandom)));
    end else if (pick < 59) begin
      send_cmd(make_cmd(ACT_SCROLL, 8'($urandom), 24'($urandom), 8'($urandom), 8'($urandom)));
    end else if (pick < 95) begin
      g = ($urandom_range(9) == 0) ? GLYPH_NEWLINE : 8'($urandom);
      send_cmd(make_cmd(ACT_PUT, g, 24'($urandom), 8'($urandom), 8'($urandom)));
    end else if (pick < 125) begin
      pick_target(col, row);
      send_cmd(make_cmd(ACT_PUT_AT, 8'($urandom), 24'($urandom), col, row));
    end else if (pick < 140) begin
      send_cmd(make_cmd(ACT_BACKSPACE, 8'($urandom), 24'($urandom), 8'($urandom),
                        8'($urandom)));
    end else if (pick < 175) begin
      pick_target(col, row);
      send_cmd(make_cmd(ACT_READ, 8'($urandom), 24'($urandom), col, row));
    end else begin
      if ($urandom_range(1) == 1) begin
        col = 8'($urandom);
        row = 8'($urandom);
      end else begin
        col = 8'($urandom_range(COLUMNS - 1));
        row = 8'($urandom_range(ROWS - 1));
      end
      send_cmd(make_cmd(ACT_SET_CURSOR, 8'($urandom), 24'($urandom), col, row));
    end
  endtask

  initial begin
    int target;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // corners, off-screen targets, cursor clamping, backspace edges, palette tie
    send_cmd(make_cmd(ACT_READ, 8'h00, 24'h000000, 8'd0, 8'd0));
    send_cmd(make_cmd(ACT_PUT, 8'hFF, 24'hFFFFFF, 8'hFF, 8'hFF));
    send_cmd(make_cmd(ACT_PUT, 8'h00, 24'h000000, 8'h00, 8'h00));
    send_cmd(make_cmd(ACT_PUT, GLYPH_NEWLINE, 24'h123456, 8'd0, 8'd0));
    send_cmd(make_cmd(ACT_PUT_AT, 8'h41, 24'h808080, 8'(COLUMNS - 1), 8'(ROWS - 1)));
    send_cmd(make_cmd(ACT_READ, 8'h00, 24'h0, 8'(COLUMNS - 1), 8'(ROWS - 1)));
    send_cmd(make_cmd(ACT_PUT_AT, 8'h42, 24'hFF0000, 8'(COLUMNS), 8'd0));
    send_cmd(make_cmd(ACT_PUT_AT, 8'h43, 24'h00FF00, 8'd0, 8'(ROWS)));
    send_cmd(make_cmd(ACT_PUT_AT, 8'h44, 24'h0000FF, 8'hFF, 8'hFF));
    send_cmd(make_cmd(ACT_READ, 8'h00, 24'h0, 8'(COLUMNS), 8'(ROWS - 1)));
    send_cmd(make_cmd(ACT_READ, 8'h00, 24'h0, 8'hFF, 8'hFF));
    send_cmd(make_cmd(ACT_SET_CURSOR, 8'h00, 24'h0, 8'hFF, 8'hFF));
    send_cmd(make_cmd(ACT_SET_CURSOR, 8'h00, 24'h0, 8'(COLUMNS - 1), 8'(ROWS - 1)));
    send_cmd(make_cmd(ACT_SET_CURSOR, 8'h00, 24'h0, 8'd0, 8'd0));
    send_cmd(make_cmd(ACT_CLEAR, 8'h00, 24'h0, 8'd0, 8'd0));
    send_cmd(make_cmd(ACT_BACKSPACE, 8'h00, 24'h0, 8'd0, 8'd0));
    send_cmd(make_cmd(ACT_PUT, GLYPH_NEWLINE, 24'h0, 8'd0, 8'd0));
    send_cmd(make_cmd(ACT_BACKSPACE, 8'h00, 24'h0, 8'd0, 8'd0));
    send_cmd(make_cmd(ACT_BACKSPACE, 8'h00, 24'h0, 8'd0, 8'd0));
    // brown and dark gray sit at equal distance from this color
    send_cmd(make_cmd(ACT_FILL, 8'h00, 24'h555500, 8'd0, 8'd0));
    send_cmd(make_cmd(ACT_READ, 8'h00, 24'h0, 8'(COLUMNS - 2), 8'd0));
    send_cmd(make_cmd(ACT_SCROLL, 8'h00, 24'h0, 8'd0, 8'd0));
    send_cmd(make_cmd(ACT_READ, 8'h00, 24'h0, 8'd0, 8'(ROWS - 1)));
    send_cmd(make_cmd(ACT_PUT_AT, GLYPH_NEWLINE, 24'h0000FF, 8'd0, 8'd0));
    send_cmd(make_cmd(ACT_READ, 8'h00, 24'h0, 8'd0, 8'd0));

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = idle_mode[phase];
      stall_pct = stall_mode[phase];
      target    = sent + RANDOM_PER_PHASE;
      while (sent < target) random_burst();
    end

    cmd_valid <= 1'b0;
    stall_pct = 0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);

    $display("%0d commands over four pacing phases, %0d response beats checked",
             sent + offscreen, checked);
    $display("%0d cell reads, %0d off-screen targets, %0d clears, fills and scrolls",
             reads, offscreen, wide_ops);
    if (errors == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// File: sim.f
rtl/tcw_pkg.sv
rtl/tcw_palette.sv
rtl/tcw_screen_ram.sv
rtl/text_console_writer_core.sv
test/text_console_writer_checker.sv
test/text_console_writer_core_tb.sv
